[rtl/core/packet0_command_stream_checker_macros.svh]
// ----------------------------------------------------------------------------
// packet0 command stream checker assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef PACKET0_COMMAND_STREAM_CHECKER_MACROS_SVH
`define PACKET0_COMMAND_STREAM_CHECKER_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define P0CSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define P0CSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/p0csc_pkg.sv]
// ----------------------------------------------------------------------------
// p0csc_pkg
// types and codes shared by the packet0 command stream checker
// ----------------------------------------------------------------------------
package p0csc_pkg;

    typedef logic [2:0] t_err;

    localparam t_err ERR_NONE   = 3'd0;
    localparam t_err ERR_TYPE   = 3'd1;
    localparam t_err ERR_TRUNC  = 3'd2;
    localparam t_err ERR_DATA   = 3'd3;
    localparam t_err ERR_ONEREG = 3'd4;
    localparam t_err ERR_INDEX  = 3'd5;
    localparam t_err ERR_WINDOW = 3'd6;

    localparam int WORD_W  = 32;
    localparam int WIN_W   = 18;
    localparam int PORT_W  = 17;
    localparam int COUNT_W = 14;
    localparam int LEFT_W  = 15;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_WINDOW_FIRST = 2'd0;
    localparam t_cfg_idx CFG_WINDOW_END   = 2'd1;
    localparam t_cfg_idx CFG_INDEX_PORT   = 2'd2;
    localparam t_cfg_idx CFG_DATA_PORT    = 2'd3;

    localparam logic [WIN_W-1:0]  RST_WINDOW_FIRST = 18'd17920;
    localparam logic [WIN_W-1:0]  RST_WINDOW_END   = 18'd19968;
    localparam logic [PORT_W-1:0] RST_INDEX_PORT   = 17'd16976;
    localparam logic [PORT_W-1:0] RST_DATA_PORT    = 17'd16980;

    typedef struct packed {
        logic [WIN_W-1:0]  window_first;
        logic [WIN_W-1:0]  window_end;
        logic [PORT_W-1:0] index_port_addr;
        logic [PORT_W-1:0] data_port_addr;
    } t_cfg;

    typedef struct packed {
        t_err code;
        logic index_hit;
    } t_hdr_res;

endpackage

[rtl/core/p0csc_hdr_check.sv]
// ----------------------------------------------------------------------------
// p0csc_hdr_check
// classifies one type-0 packet header against the ports and register window
// ----------------------------------------------------------------------------
module p0csc_hdr_check
    import p0csc_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_last,
    input  logic              i_index_seen,
    input  t_cfg              i_cfg,
    output t_hdr_res          o_res
);

    logic [PORT_W-1:0]  w_addr;
    logic [WIN_W-1:0]   w_addr_x;
    logic [15:0]        w_last_dw;
    logic [WIN_W-1:0]   w_last_addr;
    logic [COUNT_W-1:0] w_count_m1;
    logic               w_one_reg;
    logic               w_first_ok;
    logic               w_last_ok;
    logic               w_is_data;
    logic               w_is_index;

    assign w_addr      = {i_word[14:0], 2'b00};
    assign w_addr_x    = {1'b0, w_addr};
    assign w_count_m1  = i_word[29:16];
    assign w_one_reg   = i_word[15];
    assign w_last_dw   = {1'b0, i_word[14:0]} + {2'b00, w_count_m1};
    assign w_last_addr = {w_last_dw, 2'b00};
    assign w_is_data   = (w_addr == i_cfg.data_port_addr);
    assign w_is_index  = (w_addr == i_cfg.index_port_addr);

    assign w_first_ok = ((w_addr_x >= i_cfg.window_first) && (w_addr_x < i_cfg.window_end))
                     || w_is_index || w_is_data;
    assign w_last_ok  = ((w_last_addr >= i_cfg.window_first)
                         && (w_last_addr < i_cfg.window_end))
                     || (w_last_addr == {1'b0, i_cfg.index_port_addr})
                     || (w_last_addr == {1'b0, i_cfg.data_port_addr});

    always_comb begin
        priority if (i_word[31:30] != 2'b00) begin
            o_res.code = ERR_TYPE;
        end else if (i_last) begin
            o_res.code = ERR_TRUNC;
        end else if (w_is_data) begin
            o_res.code = (!w_one_reg || !i_index_seen) ? ERR_DATA : ERR_NONE;
        end else if (w_one_reg) begin
            o_res.code = ERR_ONEREG;
        end else if (w_is_index && (w_count_m1 != '0)) begin
            o_res.code = ERR_INDEX;
        end else if (!w_first_ok || !w_last_ok) begin
            o_res.code = ERR_WINDOW;
        end else begin
            o_res.code = ERR_NONE;
        end
        o_res.index_hit = w_is_index;
    end

endmodule

[rtl/core/packet0_command_stream_checker.sv]
// ----------------------------------------------------------------------------
// packet0_command_stream_checker
// checks that a command stream holds only type-0 register-write packets
// ----------------------------------------------------------------------------
// One item (32-bit word) is taken every clock cycle; a word passes through an
// input register, is checked by a single level of compares plus the 15-bit
// payload counter, and a verdict is written to the result register when the
// last word leaves the input register. The payload counter and first-error
// register close on themselves, which sets the one-word-per-cycle rate. The
// input stalls only while a last word waits on a verdict that has not been
// taken. Configuration writes take effect on the next cycle; the user must make
// them only while no stream is in flight, as the block does not enforce this.
module packet0_command_stream_checker
    import p0csc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIN_W-1:0]     i_cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [WORD_W-1:0]    s_axis_tdata,   // [31:0] word
    input  logic                 s_axis_tlast,   // last word of the stream
    // verdict stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata    // [0] stream_ok, [3:1] error_code
);

    `include "packet0_command_stream_checker_macros.svh"

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [WORD_W-1:0] r_word;
    logic              r_last;
    logic [LEFT_W-1:0] r_payload_left;
    logic              r_index_seen;
    t_err              r_first_error;
    logic              r_out_valid;
    t_err              r_out_err;

    logic [LEFT_W-1:0] n_payload_left;
    logic              n_index_seen;
    t_err              n_first_error;
    t_err              w_code;
    logic [LEFT_W-1:0] w_left_dec;
    logic              w_adv;
    t_hdr_res          w_hdr;

    // a word leaves the input register unless it is a last word facing a full output
    assign w_adv = r_in_valid && (!r_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_first    <= RST_WINDOW_FIRST;
            r_cfg.window_end      <= RST_WINDOW_END;
            r_cfg.index_port_addr <= RST_INDEX_PORT;
            r_cfg.data_port_addr  <= RST_DATA_PORT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW_FIRST: r_cfg.window_first    <= i_cfg_data;
                CFG_WINDOW_END:   r_cfg.window_end      <= i_cfg_data;
                CFG_INDEX_PORT:   r_cfg.index_port_addr <= i_cfg_data[PORT_W-1:0];
                CFG_DATA_PORT:    r_cfg.data_port_addr  <= i_cfg_data[PORT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_word <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
    end

    p0csc_hdr_check u_hdr_check (
        .i_word       (r_word),
        .i_last       (r_last),
        .i_index_seen (r_index_seen),
        .i_cfg        (r_cfg),
        .o_res        (w_hdr)
    );

    assign w_left_dec = r_payload_left - LEFT_W'(1);

    always_comb begin
        n_index_seen   = r_index_seen;
        n_payload_left = r_payload_left;
        if (r_payload_left != '0) begin
            n_payload_left = w_left_dec;
            w_code = (r_last && (w_left_dec != '0)) ? ERR_TRUNC : ERR_NONE;
        end else begin
            w_code = w_hdr.code;
            n_payload_left = {1'b0, r_word[29:16]} + LEFT_W'(1);
            if ((w_hdr.code == ERR_NONE) && w_hdr.index_hit) begin
                n_index_seen = 1'b1;
            end
        end
        // only the first error of a stream is kept
        n_first_error = (r_first_error == ERR_NONE) ? w_code : r_first_error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_left <= '0;
            r_index_seen   <= 1'b0;
            r_first_error  <= ERR_NONE;
        end else if (w_adv) begin
            if (r_last) begin
                r_payload_left <= '0;
                r_index_seen   <= 1'b0;
                r_first_error  <= ERR_NONE;
            end else begin
                r_payload_left <= n_payload_left;
                r_index_seen   <= n_index_seen;
                r_first_error  <= n_first_error;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_last) begin
            r_out_err <= n_first_error;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_err, (r_out_err == ERR_NONE)};

    `P0CSC_ASSERT_NEXT(a_clear_after_last, w_adv && r_last,
        (r_payload_left == '0) && !r_index_seen && (r_first_error == ERR_NONE),
        "stream state not cleared after last item")
    `P0CSC_ASSERT_NEXT(a_first_error_sticky,
        (r_first_error != ERR_NONE) && !(w_adv && r_last),
        $stable(r_first_error), "recorded first error changed within a stream")
    `P0CSC_ASSERT_NEXT(a_no_verdict_overwrite, r_out_valid && !m_axis_tready,
        r_out_valid && $stable(r_out_err), "pending verdict lost or changed")
    `P0CSC_ASSERT_SAME(a_err_code_range, 1'b1,
        (r_first_error != 3'd7) && (r_out_err != 3'd7 || !r_out_valid),
        "error code outside defined set")

endmodule
